// File: sv/fmc_pkg.sv
// ----------------------------------------------------------------------------
// fmc_pkg - footswitch mode controller shared definitions
// Types and codes used by the front, queue and back of the controller.
// ----------------------------------------------------------------------------
package fmc_pkg;

	// Per-button mode codes; codes above MD_LATCH_HOLD behave as MD_OFF
	typedef enum logic [2:0] {
		MD_OFF        = 3'd0,
		MD_MOMENT     = 3'd1,
		MD_ONESHOT    = 3'd2,
		MD_LATCH      = 3'd3,
		MD_LATCH_HOLD = 3'd4
	} mode_t;

	// Message codes on the result
	typedef enum logic [1:0] {
		MSG_NONE   = 2'd0,
		MSG_ACTION = 2'd1,
		MSG_REVERT = 2'd2
	} msg_t;

	// Classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_NONE       = 3'd0, // no LED write, no message
		OP_HIT        = 3'd1, // lit, action
		OP_TOGGLE     = 3'd2, // flip latch, report new state
		OP_REL_REVERT = 3'd3, // dimmed, revert
		OP_REL_DIM    = 3'd4, // dimmed, no message
		OP_REL_LONG   = 3'd5  // clear latch if held long enough
	} op_t;

	// Configuration register indexes
	localparam logic CFG_BUTTON_MODES = 1'b0;
	localparam logic CFG_LONG_PRESS   = 1'b1;

	localparam logic [23:0] MODES_RESET      = 24'd0;
	localparam logic [15:0] LONG_PRESS_RESET = 16'd600;

	// One queued request
	typedef struct packed {
		logic [2:0]  button;
		logic        store_time;
		op_t         op;
		logic [31:0] now_ms;
	} entry_t;

endpackage

// File: sv/fmc_front.sv
// ----------------------------------------------------------------------------
// fmc_front - request classifier
// Looks up the button mode and turns a button edge into a back-end operation.
// ----------------------------------------------------------------------------
module fmc_front
	import fmc_pkg::*;
#(
	parameter int BUTTON_COUNT = 8
) (
	input  logic [2:0]  button,
	input  logic        pressed,
	input  logic [31:0] now_ms,
	input  logic [23:0] button_modes,
	output entry_t      entry
);

	localparam logic [3:0] BTN_LIM = 4'(BUTTON_COUNT);

	logic        in_range;
	logic [23:0] modes_sh;
	logic [2:0]  mode;
	op_t         op;

	assign in_range = {1'b0, button} < BTN_LIM;
	assign modes_sh = button_modes >> ({2'b00, button} * 5'd3);
	assign mode     = modes_sh[2:0];

	always_comb begin
		op = OP_NONE;
		if (in_range) begin
			if (pressed) begin
				unique case (mode) inside
					MD_MOMENT, MD_ONESHOT:   op = OP_HIT;
					MD_LATCH, MD_LATCH_HOLD: op = OP_TOGGLE;
					default:                 op = OP_NONE;
				endcase
			end else begin
				unique case (mode)
					MD_MOMENT:     op = OP_REL_REVERT;
					MD_ONESHOT:    op = OP_REL_DIM;
					MD_LATCH_HOLD: op = OP_REL_LONG;
					default:       op = OP_NONE;
				endcase
			end
		end
	end

	// Every in-range press records its time, whatever the mode
	assign entry.button     = button;
	assign entry.store_time = pressed & in_range;
	assign entry.op         = op;
	assign entry.now_ms     = now_ms;

endmodule

// File: sv/fmc_queue.sv
// ----------------------------------------------------------------------------
// fmc_queue - request queue
// Small first-in first-out buffer between classifier and executor.
// ----------------------------------------------------------------------------
module fmc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count past depth");

endmodule

// File: sv/fmc_back.sv
// ----------------------------------------------------------------------------
// fmc_back - operation executor
// Holds latch and press-time state and registers one result per request.
// ----------------------------------------------------------------------------
module fmc_back
	import fmc_pkg::*;
#(
	parameter int BUTTON_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  entry_t      q_entry,
	output logic        q_pop,
	input  logic [15:0] long_press_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_button,
	output logic        out_led_write,
	output logic        out_led_bright,
	output logic [1:0]  out_msg
);

	localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

	logic                 latched_q     [BUTTON_COUNT];
	logic [31:0]          press_start_q [BUTTON_COUNT];
	logic                 out_valid_q;
	logic [2:0]           out_button_q;
	logic                 out_wr_q;
	logic                 out_br_q;
	msg_t                 out_msg_q;

	logic [IDX_W-1:0]     idx;
	logic                 lat_rd;
	logic [31:0]          held;
	logic                 long_hold;
	logic                 lat_we;
	logic                 lat_wd;
	logic                 wr;
	logic                 br;
	msg_t                 msg;

	assign idx       = q_entry.button[IDX_W-1:0];
	assign lat_rd    = latched_q[idx];
	assign held      = q_entry.now_ms - press_start_q[idx];
	assign long_hold = held >= {16'd0, long_press_ms};
	assign q_pop     = q_valid & (~out_valid_q | out_ready);

	always_comb begin
		lat_we = 1'b0;
		lat_wd = 1'b0;
		wr     = 1'b0;
		br     = 1'b0;
		msg    = MSG_NONE;
		unique case (q_entry.op)
			OP_HIT: begin
				wr  = 1'b1;
				br  = 1'b1;
				msg = MSG_ACTION;
			end
			OP_TOGGLE: begin
				lat_we = 1'b1;
				lat_wd = ~lat_rd;
				wr     = 1'b1;
				br     = ~lat_rd;
				msg    = lat_rd ? MSG_REVERT : MSG_ACTION;
			end
			OP_REL_REVERT: begin
				wr  = 1'b1;
				msg = MSG_REVERT;
			end
			OP_REL_DIM: begin
				wr = 1'b1;
			end
			OP_REL_LONG: begin
				if (lat_rd && long_hold) begin
					lat_we = 1'b1;
					wr     = 1'b1;
					msg    = MSG_REVERT;
				end
			end
			default: begin
				wr = 1'b0;
			end
		endcase
	end

	// Per-button state; reads of a new press see zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				latched_q[i]     <= 1'b0;
				press_start_q[i] <= 32'd0;
			end
		end else if (q_pop) begin
			if (lat_we) begin
				latched_q[idx] <= lat_wd;
			end
			if (q_entry.store_time) begin
				press_start_q[idx] <= q_entry.now_ms;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_button_q <= q_entry.button;
			out_wr_q     <= wr;
			out_br_q     <= br;
			out_msg_q    <= msg;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_button     = out_button_q;
	assign out_led_write  = out_wr_q;
	assign out_led_bright = out_br_q;
	assign out_msg        = out_msg_q;

	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_wr_q |-> !out_br_q && out_msg_q == MSG_NONE)
		else $error("no-write result carries brightness or message");

	a_revert_dim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_msg_q == MSG_REVERT |-> out_wr_q && !out_br_q)
		else $error("revert result not dimmed");

	a_toggle_flips: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_entry.op == OP_TOGGLE |=> latched_q[$past(idx)] != $past(lat_rd))
		else $error("toggle did not flip latch");

endmodule

// File: sv/footswitch_mode_controller_top.sv
// ----------------------------------------------------------------------------
// footswitch_mode_controller_top - footswitch mode controller
// Turns debounced button edges into LED updates and action/revert messages.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready button edge request
//  m_axis    out        m_axis_tvalid/m_axis_tready one result per request
//  cfg       in         cfg_we (no wait)            button_modes, long_press_ms
//
//  One request per clock, sustained while the output is not stalled. A request
//  accepted from s_axis enters the two-entry queue; the executor pops it from
//  there and loads its result into the output register, which drives m_axis.
//  Reset clears the latches and press times to zero, button_modes to zero and
//  long_press_ms to 600, and empties the queue.
//  A stalled result holds the output register; the executor then stops popping
//  and s_axis_tready falls once the queue holds two requests.
//
module footswitch_mode_controller_top
	import fmc_pkg::*;
#(
	parameter int BUTTON_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Button edge requests
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [2:0] button, [34:3] now_ms, [39:35] zero
	input  logic        s_axis_tuser,  // [0] pressed
	// Results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [2:0] target_button, [3] led_write,
	                                   // [4] led_bright, [7:5] zero
	output logic [1:0]  m_axis_tuser,  // [1:0] message_kind
	// Configuration writes
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int ENTRY_W = $bits(entry_t);

	logic [23:0]        button_modes_q;
	logic [15:0]        long_press_ms_q;
	entry_t             front_entry;
	entry_t             back_entry;
	logic [ENTRY_W-1:0] q_rd_data;
	logic               q_full;
	logic               q_valid;
	logic               q_pop;
	logic               push;
	logic [2:0]         out_button;
	logic               out_wr;
	logic               out_br;
	logic [1:0]         out_msg;

	// Configuration registers; the user must write them only while idle (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_modes_q  <= MODES_RESET;
			long_press_ms_q <= LONG_PRESS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BUTTON_MODES: button_modes_q  <= cfg_data;
				CFG_LONG_PRESS:   long_press_ms_q <= cfg_data[15:0];
				default:          button_modes_q  <= button_modes_q;
			endcase
		end
	end

	// Front: classify the edge by the button's mode
	fmc_front #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_front (
		.button       (s_axis_tdata[2:0]),
		.pressed      (s_axis_tuser),
		.now_ms       (s_axis_tdata[34:3]),
		.button_modes (button_modes_q),
		.entry        (front_entry)
	);

	// Accept whenever the queue has room
	assign s_axis_tready = ~q_full;
	assign push          = s_axis_tvalid & ~q_full;

	fmc_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_rd_data)
	);

	assign back_entry = q_rd_data;

	// Back: apply the operation to per-button state and register the result
	fmc_back #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_entry        (back_entry),
		.q_pop          (q_pop),
		.long_press_ms  (long_press_ms_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_button     (out_button),
		.out_led_write  (out_wr),
		.out_led_bright (out_br),
		.out_msg        (out_msg)
	);

	assign m_axis_tdata = {3'b000, out_br, out_wr, out_button};
	assign m_axis_tuser = out_msg;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - footswitch mode controller testbench
// Sends button edge requests and keeps a cycle-free model of the per-button
// latches and press times. Each result is checked field by field against the
// oldest predicted result. The run has a directed pass over every mode, then
// random press/release sequences under several configurations, and a long
// output stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_top
	import fmc_pkg::*;
();

	localparam int BTN_TOTAL      = 8;
	localparam int DRAIN_CYCLES   = 8;     // idle margin after the last predicted result
	localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
	localparam int IDLE_PERCENT   = 13;
	localparam int NOISE_PERCENT  = 15;
	localparam int MAX_REPORTS    = 10;
	localparam int STALL_CYCLES   = 80;

	// Mode codes with no meaning of their own; the block treats them as none
	localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
	localparam logic [2:0] MODE_SPARE_MID = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

	// Every button in switch-momentary mode
	localparam logic [23:0] ALL_SWITCH_MOM = {8{MD_LATCH_HOLD}};
	localparam logic [23:0] ALL_SPARE_HI   = {8{MODE_SPARE_HI}};

	typedef struct {
		logic [2:0] button;
		logic       led_write;
		logic       led_bright;
		msg_t       msg;
	} led_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // [2:0] button, [34:3] now_ms, [39:35] zero
	logic        s_axis_tuser;   // [0] pressed
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // [2:0] target_button, [3] led_write,
	                             // [4] led_bright, [7:5] zero
	logic [1:0]  m_axis_tuser;   // [1:0] message_kind
	logic        cfg_we;
	logic        cfg_index;
	logic [23:0] cfg_data;

	// Shadow of the block: configuration and per-button state
	logic [23:0] mode_bits;
	logic [15:0] long_press;
	logic        latched [BTN_TOTAL];
	logic [31:0] press_time [BTN_TOTAL];

	// LED updates predicted but not yet seen on the output
	led_result_t expected_leds[$];

	// Stimulus generator: which buttons it believes are down, and since when
	logic        gen_down [BTN_TOTAL];
	logic [31:0] gen_at [BTN_TOTAL];
	logic [31:0] ms_clock;

	bit gaps_on;           // random idling on both sides
	int stall_cycles;      // receiver hold-off still to run
	int fail_count;

	footswitch_mode_controller_top #(
		.BUTTON_COUNT(BTN_TOTAL)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor: apply one button edge to the shadow state, return the update
	// ------------------------------------------------------------------------
	function automatic led_result_t step_footswitch(input logic [2:0] btn,
			input logic pressed, input logic [31:0] now);
		led_result_t res;
		logic [2:0]  mode;
		logic [31:0] held;
		res = '{button: btn, led_write: 1'b0, led_bright: 1'b0, msg: MSG_NONE};
		// Out-of-range buttons touch no state and produce the quiet result
		if (btn >= BTN_TOTAL)
			return res;
		mode = mode_bits[3*btn +: 3];
		if (pressed) begin
			// Every press records its time, even in mode none
			press_time[btn] = now;
			case (mode) inside
				MD_MOMENT, MD_ONESHOT: begin
					res.led_write  = 1'b1;
					res.led_bright = 1'b1;
					res.msg        = MSG_ACTION;
				end
				MD_LATCH, MD_LATCH_HOLD: begin
					latched[btn]   = !latched[btn];
					res.led_write  = 1'b1;
					res.led_bright = latched[btn];
					res.msg        = latched[btn] ? MSG_ACTION : MSG_REVERT;
				end
				default: ;
			endcase
		end else begin
			// Hold time wraps modulo 2^32
			held = now - press_time[btn];
			case (mode)
				MD_MOMENT: begin
					res.led_write = 1'b1;
					res.msg       = MSG_REVERT;
				end
				MD_ONESHOT:
					res.led_write = 1'b1;
				MD_LATCH_HOLD: begin
					if (latched[btn] && held >= {16'd0, long_press}) begin
						latched[btn]  = 1'b0;
						res.led_write = 1'b1;
						res.msg       = MSG_REVERT;
					end
				end
				default: ;
			endcase
		end
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Sender: offer one request, predict it at the cycle it is taken.
	// Entered and left at a rising edge; tvalid stays high on return so that
	// a following request can go out back to back.
	// ------------------------------------------------------------------------
	task automatic send_edge(input logic [2:0] btn, input logic pressed,
			input logic [31:0] now);
		if (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'd0, now, btn};
		s_axis_tuser  <= pressed;
		// Sample tready mid-cycle, where nothing is moving
		@(negedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
			@(negedge clk);
		end
		expected_leds.push_back(step_footswitch(btn, pressed, now));
		@(posedge clk);
	endtask

	// Drop tvalid and wait until every predicted update has come out
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_leds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register; only called with the block idle
	task automatic write_reg(input logic idx, input logic [23:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_BUTTON_MODES)
			mode_bits = value;
		else
			long_press = value[15:0];
		@(posedge clk);
	endtask

	// Mostly well-formed press/release pairs with releases landing around the
	// long-press threshold or at random hold times; the rest is noise on any button
	task automatic play_random_edges(input int count);
		logic [2:0]  btn;
		logic        pressed;
		logic [31:0] now;
		logic [31:0] hold;
		repeat (count) begin
			btn = 3'($urandom_range(BTN_TOTAL - 1));
			if ($urandom_range(99) < NOISE_PERCENT) begin
				pressed = 1'($urandom_range(1));
				now     = $urandom;
			end else if (gen_down[btn]) begin
				pressed = 1'b0;
				case ($urandom_range(4))
					0:       hold = {16'd0, long_press} - 32'd1;
					1:       hold = {16'd0, long_press};
					2:       hold = {16'd0, long_press} + 32'd1;
					3:       hold = $urandom_range(0, 2000);
					default: hold = $urandom;
				endcase
				now = gen_at[btn] + hold;
			end else begin
				pressed = 1'b1;
				now     = ms_clock + $urandom_range(0, 3000);
			end
			ms_clock      = now;
			gen_down[btn] = pressed;
			if (pressed)
				gen_at[btn] = now;
			send_edge(btn, pressed, now);
		end
	endtask

	// One random phase under a fresh configuration
	task automatic run_phase(input logic [23:0] modes, input logic [15:0] threshold,
			input bit idle, input int count);
		drain_results();
		gaps_on = idle;
		write_reg(CFG_BUTTON_MODES, modes);
		write_reg(CFG_LONG_PRESS, {8'd0, threshold});
		ms_clock = $urandom;
		play_random_edges(count);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Every mode on its own button, with the reset threshold of 600 ms
	task automatic test_directed();
		logic [31:0] t0;
		t0 = 32'hFFFF_FF00;
		// Reset modes are all none: a release with no press, a press at the top
		// of the time range
		send_edge(3'd4, 1'b0, 32'd0);
		send_edge(3'd0, 1'b1, 32'hFFFF_FFFF);
		drain_results();
		write_reg(CFG_BUTTON_MODES, {MODE_SPARE_HI, MODE_SPARE_MID, MODE_SPARE_LO,
			MD_LATCH_HOLD, MD_LATCH, MD_ONESHOT, MD_MOMENT, MD_OFF});
		// Momentary and single shot
		send_edge(3'd1, 1'b1, 32'd100);
		send_edge(3'd1, 1'b0, 32'd150);
		send_edge(3'd2, 1'b1, 32'd0);
		send_edge(3'd2, 1'b0, 32'hFFFF_FFFF);
		// Switch: toggle on, release ignored, toggle off, toggle on
		send_edge(3'd3, 1'b1, 32'd10);
		send_edge(3'd3, 1'b0, 32'd20);
		send_edge(3'd3, 1'b1, 32'd30);
		send_edge(3'd3, 1'b1, 32'd40);
		// Switch momentary: release before any press, short hold across the
		// wrap, press to clear, press to set, release right at the threshold
		send_edge(3'd4, 1'b0, 32'd5000);
		send_edge(3'd4, 1'b1, t0);
		send_edge(3'd4, 1'b0, t0 + 32'd599);
		send_edge(3'd4, 1'b1, 32'h0000_0200);
		send_edge(3'd4, 1'b1, 32'h0000_0300);
		send_edge(3'd4, 1'b0, 32'h0000_0300 + 32'd600);
		// Spare codes and none do nothing
		send_edge(3'd5, 1'b1, 32'd1);
		send_edge(3'd6, 1'b1, 32'd2);
		send_edge(3'd7, 1'b1, 32'd3);
		send_edge(3'd0, 1'b1, 32'd4);
		send_edge(3'd0, 1'b0, 32'd5);
	endtask

	task automatic test_random_phases();
		logic [23:0] mixed;
		run_phase(24'($urandom), 16'($urandom_range(0, 1000)), 1'b1, 60);
		// Threshold extremes with every button in switch-momentary mode
		run_phase(ALL_SWITCH_MOM, 16'h0000, 1'b1, 55);
		run_phase(ALL_SWITCH_MOM, 16'hFFFF, 1'b1, 55);
		run_phase(ALL_SPARE_HI, 16'($urandom), 1'b1, 40);
		// Only real modes, and a long stretch with no idling on either side
		for (int i = 0; i < BTN_TOTAL; i++)
			mixed[3*i +: 3] = 3'($urandom_range(MD_LATCH_HOLD));
		run_phase(mixed, 16'($urandom_range(0, 3000)), 1'b0, 70);
		run_phase(24'($urandom), 16'($urandom), 1'b1, 55);
	endtask

	// Hold the output off long enough for the queue to fill and the input to
	// stall, while requests keep coming back to back
	task automatic test_backpressure();
		drain_results();
		gaps_on      = 1'b0;
		stall_cycles = STALL_CYCLES;
		play_random_edges(40);
		gaps_on = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random idling, or a counted hold-off when one is asked for
	// ------------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (stall_cycles > 0) begin
				m_axis_tready <= 1'b0;
				stall_cycles--;
			end else if (gaps_on) begin
				m_axis_tready <= ($urandom_range(99) >= IDLE_PERCENT);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checker: sample mid-cycle, the result moves at the next edge
	// ------------------------------------------------------------------------
	initial begin : result_checker
		led_result_t want;
		forever begin
			@(negedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (expected_leds.size() == 0) begin
					if (fail_count < MAX_REPORTS)
						$display("[%0t] unexpected result: button %0d write %0b bright %0b msg %0d",
							$time, m_axis_tdata[2:0], m_axis_tdata[3], m_axis_tdata[4],
							m_axis_tuser);
					fail_count++;
				end else begin
					want = expected_leds.pop_front();
					if (m_axis_tdata[2:0] !== want.button || m_axis_tdata[3] !== want.led_write
							|| m_axis_tdata[4] !== want.led_bright || m_axis_tuser !== want.msg) begin
						if (fail_count < MAX_REPORTS)
							$display({"[%0t] mismatch: button exp %0d got %0d, write exp %0b got %0b,",
								" bright exp %0b got %0b, msg exp %0d got %0d"}, $time,
								want.button, m_axis_tdata[2:0], want.led_write, m_axis_tdata[3],
								want.led_bright, m_axis_tdata[4], want.msg, m_axis_tuser);
						fail_count++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: give up after a long run of cycles with no handshake at all
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] watchdog: no handshake for %0d cycles, %0d results outstanding",
			$time, WATCHDOG_LIMIT, expected_leds.size());
		$display("footswitch_mode_controller_top verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		// Hold every input at a known value from time zero
		arst_n        = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		m_axis_tready <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_BUTTON_MODES;
		cfg_data      <= '0;
		gaps_on       = 1'b1;
		stall_cycles  = 0;
		fail_count    = 0;
		// Shadow state matches the block after reset
		mode_bits  = MODES_RESET;
		long_press = LONG_PRESS_RESET;
		for (int i = 0; i < BTN_TOTAL; i++) begin
			latched[i]    = 1'b0;
			press_time[i] = '0;
			gen_down[i]   = 1'b0;
			gen_at[i]     = '0;
		end
		ms_clock = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_phases();
		test_backpressure();
		drain_results();

		if (fail_count == 0 && expected_leds.size() == 0) begin
			$display("footswitch_mode_controller_top verification clean");
		end else begin
			$display("footswitch_mode_controller_top verification failed");
		end
		$finish;
	end

endmodule
